// File: sv/affine_2d_transform_compose_top_assert.svh
// Assertion macros for the affine transform composer checker.
// Used only by afc_checker; needs nothing else.
`ifndef AFFINE_2D_TRANSFORM_COMPOSE_TOP_ASSERT_SVH
`define AFFINE_2D_TRANSFORM_COMPOSE_TOP_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define AFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("afc assertion failed");

// implication with the consequent delayed by the dly argument
`define AFC_ASSERT_LAT(lbl, clk, rst, dly, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("afc assertion failed");

`endif

// File: sv/afc_pkg.sv
// Shared constants, types and helpers for the affine transform composer.
// No dependencies.
package afc_pkg;

   localparam int ANGLE_BITS  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int TRIG_STAGES = 16;

   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

   // CORDIC datapath, Q30 with headroom
   localparam int CORDIC_W = 34;
   localparam int ROUND_SH = 30 - FRAC_BITS;
   localparam int RND_W    = CORDIC_W - ROUND_SH;
   localparam int TRIG_W   = FRAC_BITS + 2;

   // scale (Q8.8) times trig (Q FRAC_BITS), then back to Q16.16
   localparam int PROD_W   = 16 + TRIG_W;
   localparam int SCALE_SH = FRAC_BITS - 8;
   localparam int ENTRY_W  = PROD_W - SCALE_SH;
   localparam int TERM_W   = 32 + ENTRY_W;
   localparam int SUM_W    = TERM_W + 2;
   localparam int SAT_W    = SUM_W - 16;

   // accept edge to the edge at which the result beat is taken
   localparam int LATENCY = TRIG_STAGES + 6;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
   } side_type;

   typedef struct packed {
      logic                       valid;
      logic [1:0]                 quad;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      side_type                   side;
   } cordic_type;

   typedef struct packed {
      logic                     valid;
      logic signed [TRIG_W-1:0] cos_v;
      logic signed [TRIG_W-1:0] sin_v;
      side_type                 side;
   } trig_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
   } rsp_type;

   // round half up from PROD_W (Q FRAC_BITS+8) to a Q16.16 entry
   function automatic logic signed [ENTRY_W-1:0] round_entry(
      input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] bias;
      logic signed [PROD_W-1:0] sum;
      bias = (SCALE_SH > 0) ? (PROD_W'(1) << (SCALE_SH - 1)) : '0;
      sum  = (v + bias) >>> SCALE_SH;
      return sum[ENTRY_W-1:0];
   endfunction

   // clip to the int32 range
   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic hi_ok;
      logic lo_ok;
      hi_ok = &v[SAT_W-1:31];
      lo_ok = ~|v[SAT_W-1:31];
      if (hi_ok || lo_ok) begin
         return v[31:0];
      end
      return v[SAT_W-1] ? 32'sh80000000 : 32'sh7fffffff;
   endfunction

endpackage

// File: sv/afc_cordic_cell.sv
// One CORDIC rotation cell of the trig chain: one micro-rotation per beat.
// Depends on afc_pkg.
module afc_cordic_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [afc_pkg::ATAN_IDX_W-1:0]   stage,
   input  afc_pkg::cordic_type              up_data,
   output afc_pkg::cordic_type              dn_data
);
   import afc_pkg::*;

   logic                       valid_ff, valid_in;
   cordic_type                 data_ff, data_in;
   logic signed [CORDIC_W-1:0] x_cur, y_cur, z_cur, dx, dy, atan_ext;

   always_comb begin
      x_cur    = up_data.x;
      y_cur    = up_data.y;
      z_cur    = up_data.z;
      dx       = y_cur >>> stage;
      dy       = x_cur >>> stage;
      atan_ext = {{(CORDIC_W-32){1'b0}}, ATAN_TURNS[stage]};
      valid_in = up_data.valid;
      data_in  = up_data;
      if (!z_cur[CORDIC_W-1]) begin
         data_in.x = x_cur - dx;
         data_in.y = y_cur + dy;
         data_in.z = z_cur - atan_ext;
      end else begin
         data_in.x = x_cur + dx;
         data_in.y = y_cur - dy;
         data_in.z = z_cur + atan_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      dn_data       = data_ff;
      dn_data.valid = valid_ff;
   end

endmodule

// File: sv/afc_trig_round.sv
// Quadrant fix-up, rounding and clamping of the CORDIC output to cos/sin.
// Depends on afc_pkg.
module afc_trig_round (
   input  logic                clock,
   input  logic                reset,
   input  afc_pkg::cordic_type cordic_data,
   output afc_pkg::trig_type   trig_data
);
   import afc_pkg::*;

   localparam logic signed [CORDIC_W-1:0] RND_BIAS =
      CORDIC_W'(1) << (ROUND_SH - 1);
   localparam logic signed [RND_W-1:0] UNIT_POS =
      {{(RND_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [RND_W-1:0] UNIT_NEG = -UNIT_POS;

   logic                       valid_ff, valid_in;
   trig_type                   data_ff, data_in;
   logic signed [CORDIC_W-1:0] c_sel, s_sel, c_sh, s_sh;
   logic signed [RND_W-1:0]    c_rnd, s_rnd, c_clp, s_clp;

   always_comb begin
      unique case (cordic_data.quad)
         2'd0: begin
            c_sel = cordic_data.x;
            s_sel = cordic_data.y;
         end
         2'd1: begin
            c_sel = -cordic_data.y;
            s_sel = cordic_data.x;
         end
         2'd2: begin
            c_sel = -cordic_data.x;
            s_sel = -cordic_data.y;
         end
         default: begin
            c_sel = cordic_data.y;
            s_sel = -cordic_data.x;
         end
      endcase
      c_sh  = (c_sel + RND_BIAS) >>> ROUND_SH;
      s_sh  = (s_sel + RND_BIAS) >>> ROUND_SH;
      c_rnd = c_sh[RND_W-1:0];
      s_rnd = s_sh[RND_W-1:0];
      priority if (c_rnd > UNIT_POS) c_clp = UNIT_POS;
      else if (c_rnd < UNIT_NEG)     c_clp = UNIT_NEG;
      else                           c_clp = c_rnd;
      priority if (s_rnd > UNIT_POS) s_clp = UNIT_POS;
      else if (s_rnd < UNIT_NEG)     s_clp = UNIT_NEG;
      else                           s_clp = s_rnd;
      valid_in      = cordic_data.valid;
      data_in.valid = cordic_data.valid;
      data_in.cos_v = c_clp[TRIG_W-1:0];
      data_in.sin_v = s_clp[TRIG_W-1:0];
      data_in.side  = cordic_data.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      trig_data       = data_ff;
      trig_data.valid = valid_ff;
   end

endmodule

// File: sv/afc_matrix.sv
// Matrix entries and translations from cos/sin: four pipeline stages
// (scale products, origin products, sums, round and saturate). Depends on afc_pkg.
module afc_matrix (
   input  logic              clock,
   input  logic              reset,
   input  afc_pkg::trig_type trig_data,
   output logic              rsp_strobe,
   output afc_pkg::rsp_type  rsp_data
);
   import afc_pkg::*;

   localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(32768);

   typedef struct packed {
      logic signed [ENTRY_W-1:0] e00;
      logic signed [ENTRY_W-1:0] e01;
      logic signed [ENTRY_W-1:0] e10;
      logic signed [ENTRY_W-1:0] e11;
      logic signed [31:0]        pos_x;
      logic signed [31:0]        pos_y;
      logic signed [31:0]        origin_x;
      logic signed [31:0]        origin_y;
   } ent_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] e00;
      logic signed [ENTRY_W-1:0] e01;
      logic signed [ENTRY_W-1:0] e10;
      logic signed [ENTRY_W-1:0] e11;
      logic signed [31:0]        pos_x;
      logic signed [31:0]        pos_y;
      logic signed [TERM_W-1:0]  p00;
      logic signed [TERM_W-1:0]  p01;
      logic signed [TERM_W-1:0]  p10;
      logic signed [TERM_W-1:0]  p11;
   } term_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] e00;
      logic signed [ENTRY_W-1:0] e01;
      logic signed [ENTRY_W-1:0] e10;
      logic signed [ENTRY_W-1:0] e11;
      logic signed [SUM_W-1:0]   tx;
      logic signed [SUM_W-1:0]   ty;
   } sum_type;

   logic [3:0]               valid_ff, valid_in;
   ent_type                  ent_ff, ent_in;
   term_type                 term_ff, term_in;
   sum_type                  sum_ff, sum_in;
   rsp_type                  out_ff, out_in;
   logic signed [PROD_W-1:0] pa, pb, pc, pd;
   logic signed [SUM_W-1:0]  tx_sh, ty_sh;

   always_comb begin
      valid_in = {valid_ff[2:0], trig_data.valid};

      // scale times trig
      pa = PROD_W'(trig_data.side.scale_x) * PROD_W'(trig_data.cos_v);
      pb = PROD_W'(trig_data.side.scale_y) * PROD_W'(trig_data.sin_v);
      pc = PROD_W'(trig_data.side.scale_x) * PROD_W'(trig_data.sin_v);
      pd = PROD_W'(trig_data.side.scale_y) * PROD_W'(trig_data.cos_v);
      ent_in.e00      = round_entry(pa);
      ent_in.e01      = round_entry(pb);
      ent_in.e10      = -round_entry(pc);
      ent_in.e11      = round_entry(pd);
      ent_in.pos_x    = trig_data.side.pos_x;
      ent_in.pos_y    = trig_data.side.pos_y;
      ent_in.origin_x = trig_data.side.origin_x;
      ent_in.origin_y = trig_data.side.origin_y;

      // origin times entries
      term_in.e00   = ent_ff.e00;
      term_in.e01   = ent_ff.e01;
      term_in.e10   = ent_ff.e10;
      term_in.e11   = ent_ff.e11;
      term_in.pos_x = ent_ff.pos_x;
      term_in.pos_y = ent_ff.pos_y;
      term_in.p00   = TERM_W'(ent_ff.origin_x) * TERM_W'(ent_ff.e00);
      term_in.p01   = TERM_W'(ent_ff.origin_y) * TERM_W'(ent_ff.e01);
      term_in.p10   = TERM_W'(ent_ff.origin_x) * TERM_W'(ent_ff.e10);
      term_in.p11   = TERM_W'(ent_ff.origin_y) * TERM_W'(ent_ff.e11);

      // translation in Q32, rounding bias folded in
      sum_in.e00 = term_ff.e00;
      sum_in.e01 = term_ff.e01;
      sum_in.e10 = term_ff.e10;
      sum_in.e11 = term_ff.e11;
      sum_in.tx  = (SUM_W'(term_ff.pos_x) <<< 16) - SUM_W'(term_ff.p00)
                   - SUM_W'(term_ff.p01) + HALF_LSB;
      sum_in.ty  = (SUM_W'(term_ff.pos_y) <<< 16) - SUM_W'(term_ff.p10)
                   - SUM_W'(term_ff.p11) + HALF_LSB;

      tx_sh      = sum_ff.tx >>> 16;
      ty_sh      = sum_ff.ty >>> 16;
      out_in.m00 = 32'(sum_ff.e00);
      out_in.m01 = 32'(sum_ff.e01);
      out_in.m10 = 32'(sum_ff.e10);
      out_in.m11 = 32'(sum_ff.e11);
      out_in.m02 = sat32(tx_sh[SAT_W-1:0]);
      out_in.m12 = sat32(ty_sh[SAT_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      out_ff  <= out_in;
   end

   assign rsp_strobe = valid_ff[3];
   assign rsp_data   = out_ff;

endmodule

// File: sv/affine_2d_transform_compose_top.sv
// Top level of the 2D affine transform composer: angle prep stage, CORDIC cell
// chain, trig rounding and matrix pipeline. Depends on afc_pkg and the afc_* modules.
//
//   channel   direction  handshake          beat contents
//   request   in         start & !busy      req_pos_x/y, req_origin_x/y, req_scale_x/y,
//                                           req_rotation
//   response  out        rsp_strobe         rsp_m00 m01 m02 m10 m11 m12
//
// One beat accepted per clock, every clock; busy is high only during reset.
// The request beat passes, after the edge that accepts it, through the prep stage,
// the CORDIC cell chain, trig rounding and four matrix stages before the result
// beat is taken. Synchronous reset empties the pipeline; results in flight
// are dropped. The receiver cannot stall, so nothing backs up.
module affine_2d_transform_compose_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic [15:0]        req_rotation,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_m00,
   output logic signed [31:0] rsp_m01,
   output logic signed [31:0] rsp_m02,
   output logic signed [31:0] rsp_m10,
   output logic signed [31:0] rsp_m11,
   output logic signed [31:0] rsp_m12
);
   import afc_pkg::*;

   logic                  prep_valid_ff, prep_valid_in;
   cordic_type            prep_ff, prep_in;
   logic [ANGLE_BITS-1:0] rot_a, code;
   logic [31:0]           ang, ang_bias, resid;
   logic [1:0]            quad;
   cordic_type            chain [TRIG_STAGES+1];
   trig_type              trig_data;
   rsp_type               rsp_data;

   assign busy = reset;

   // negate the angle, scale it to 2^32 per turn, split off the quadrant
   always_comb begin
      rot_a    = ANGLE_BITS'(req_rotation);
      code     = ~rot_a + 1'b1;
      ang      = {code, {(32-ANGLE_BITS){1'b0}}};
      ang_bias = ang + 32'h2000_0000;
      quad     = ang_bias[31:30];
      resid    = ang - {quad, 30'b0};

      prep_valid_in         = start && !busy;
      prep_in.valid         = prep_valid_in;
      prep_in.quad          = quad;
      prep_in.x             = CORDIC_GAIN;
      prep_in.y             = '0;
      prep_in.z             = CORDIC_W'(signed'(resid));
      prep_in.side.pos_x    = req_pos_x;
      prep_in.side.pos_y    = req_pos_y;
      prep_in.side.origin_x = req_origin_x;
      prep_in.side.origin_y = req_origin_y;
      prep_in.side.scale_x  = req_scale_x;
      prep_in.side.scale_y  = req_scale_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= prep_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
   end

   always_comb begin
      chain[0]       = prep_ff;
      chain[0].valid = prep_valid_ff;
   end

   for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
      afc_cordic_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .stage   (ATAN_IDX_W'(g)),
         .up_data (chain[g]),
         .dn_data (chain[g+1])
      );
   end

   afc_trig_round u_trig (
      .clock       (clock),
      .reset       (reset),
      .cordic_data (chain[TRIG_STAGES]),
      .trig_data   (trig_data)
   );

   afc_matrix u_matrix (
      .clock      (clock),
      .reset      (reset),
      .trig_data  (trig_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   assign rsp_m00 = rsp_data.m00;
   assign rsp_m01 = rsp_data.m01;
   assign rsp_m02 = rsp_data.m02;
   assign rsp_m10 = rsp_data.m10;
   assign rsp_m11 = rsp_data.m11;
   assign rsp_m12 = rsp_data.m12;

endmodule

// File: sv/afc_checker.sv
// Port-level checker for the affine transform composer, bound to the top level.
// Depends on afc_pkg and affine_2d_transform_compose_top_assert.svh.
`include "affine_2d_transform_compose_top_assert.svh"

module afc_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_pos_x,
   input logic signed [31:0] req_pos_y,
   input logic signed [15:0] req_scale_x,
   input logic signed [15:0] req_scale_y,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_m00,
   input logic signed [31:0] rsp_m01,
   input logic signed [31:0] rsp_m02,
   input logic signed [31:0] rsp_m10,
   input logic signed [31:0] rsp_m11,
   input logic signed [31:0] rsp_m12
);
   import afc_pkg::*;

   logic zero_scale_req;
   logic zero_entries;

   assign zero_scale_req = start && !busy && req_scale_x == 16'sd0 && req_scale_y == 16'sd0;
   assign zero_entries   = rsp_m00 == 32'sd0 && rsp_m01 == 32'sd0 &&
                           rsp_m10 == 32'sd0 && rsp_m11 == 32'sd0;

   // every accepted beat comes out as a result beat
   `AFC_ASSERT_LAT(a_rsp_follows_req, clock, reset, LATENCY, start && !busy, rsp_strobe)

   // no result beat without a request beat behind it
   `AFC_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_strobe, $past(start && !busy, LATENCY))

   // zero scale leaves a pure translation
   `AFC_ASSERT_LAT(a_zero_scale, clock, reset, LATENCY, zero_scale_req,
      zero_entries && rsp_m02 == $past(req_pos_x, LATENCY) &&
      rsp_m12 == $past(req_pos_y, LATENCY))

   // reset flushes the pipeline at once
   `AFC_ASSERT_NOW(a_quiet_after_reset, clock, 1'b0, $past(reset), !rsp_strobe)

endmodule

bind affine_2d_transform_compose_top afc_checker u_afc_checker (.*);
